/* hw/rtl/txs_pkg.sv */
package txs_pkg;

  localparam int StoreAw          = 16;
  localparam int TexelW           = 24;
  localparam int ChanW            = 8;
  localparam int CoordW           = 16;
  localparam int Log2W            = 4;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 4;
  localparam int MaxSizeLog2Def   = 8;
  localparam int CoordFracBitsDef = 12;
  localparam int QueueDepth       = 2;
  localparam int OutDepth         = 4;

  localparam logic [CfgIdxW-1:0] REG_TEX_EN      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BIL_EN      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WIDTH_LOG2  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_LOG2 = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    K_LOAD,
    K_NEAR,
    K_BIL
  } kind_e;

  typedef struct packed {
    logic              operation;
    logic [15:0]       texel_index;
    logic [ChanW-1:0]  load_red;
    logic [ChanW-1:0]  load_green;
    logic [ChanW-1:0]  load_blue;
    logic [CoordW-1:0] coord_u;
    logic [CoordW-1:0] coord_v;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } out_item_t;

endpackage

/* hw/rtl/txs_ram.sv */
module txs_ram import txs_pkg::*; #(
  parameter int Width = TexelW,
  parameter int Depth = 1 << StoreAw,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/txs_fifo.sv */
module txs_fifo import txs_pkg::*; #(
  parameter int Width = TexelW,
  parameter int Depth = 2,
  localparam int PtrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/txs_front.sv */
module txs_front import txs_pkg::*; #(
  parameter int MaxLog2  = MaxSizeLog2Def,
  parameter int FracBits = CoordFracBitsDef,
  localparam int WtW    = 2*FracBits + 1,
  localparam int EntryW = $bits(kind_e) + 4*StoreAw + TexelW + 4*WtW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            item_i,
  output logic [EntryW-1:0]   entry_o
);

  localparam int XW   = FracBits + MaxLog2;
  localparam int LinW = 2*MaxLog2;
  localparam logic [XW-1:0]    Half  = XW'(1) << (FracBits-1);
  localparam logic [FracBits:0] One  = (FracBits+1)'(1) << FracBits;
  localparam logic [WtW-1:0]   NearWt = WtW'(1) << (2*FracBits);

  typedef struct packed {
    kind_e                        kind;
    logic [3:0][StoreAw-1:0]      addr;
    logic [TexelW-1:0]            data;
    logic [3:0][WtW-1:0]          wt;
  } entry_t;

  logic             tex_en_q, bil_en_q;
  logic [Log2W-1:0] wl_raw_q, hl_raw_q, wl, hl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_en_q <= 1'b0;
      bil_en_q <= 1'b0;
      wl_raw_q <= Log2W'(8);
      hl_raw_q <= Log2W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEX_EN:      tex_en_q <= cfg_data_i[0];
        REG_BIL_EN:      bil_en_q <= cfg_data_i[0];
        REG_WIDTH_LOG2:  wl_raw_q <= cfg_data_i;
        REG_HEIGHT_LOG2: hl_raw_q <= cfg_data_i;
      endcase
    end
  end

  assign wl = (wl_raw_q > Log2W'(MaxLog2)) ? Log2W'(MaxLog2) : wl_raw_q;
  assign hl = (hl_raw_q > Log2W'(MaxLog2)) ? Log2W'(MaxLog2) : hl_raw_q;

  function automatic logic [StoreAw-1:0] addr_of(input logic [MaxLog2-1:0] col,
                                                 input logic [MaxLog2-1:0] rb,
                                                 input logic [Log2W-1:0]   wlog,
                                                 input logic [Log2W-1:0]   hlog);
    logic [MaxLog2:0]   hm;
    logic [MaxLog2-1:0] row;
    logic [LinW-1:0]    lin;
    hm  = ((MaxLog2+1)'(1) << hlog) - (MaxLog2+1)'(1);
    row = ~rb & hm[MaxLog2-1:0];
    lin = (LinW'(row) << wlog) + LinW'(col);
    return StoreAw'(lin);
  endfunction

  logic [FracBits-1:0] uf, vf, fx, fy;
  logic [XW-1:0]       ux, vx, xs, ys;
  logic [XW:0]         xm, ym;
  logic [MaxLog2:0]    wm, hm;
  logic [MaxLog2-1:0]  x0, x1, y0, y1;
  logic [FracBits:0]   sx, sy;
  logic [WtW:0]        p0, p1, p2, p3;
  entry_t              e;

  always_comb begin
    uf = item_i.coord_u[FracBits-1:0];
    vf = item_i.coord_v[FracBits-1:0];
    ux = XW'(uf) << wl;
    vx = XW'(vf) << hl;
    xm = ((XW+1)'(1) << (int'(wl) + FracBits)) - (XW+1)'(1);
    ym = ((XW+1)'(1) << (int'(hl) + FracBits)) - (XW+1)'(1);
    xs = (ux - Half) & xm[XW-1:0];
    ys = (vx - Half) & ym[XW-1:0];
    wm = ((MaxLog2+1)'(1) << wl) - (MaxLog2+1)'(1);
    hm = ((MaxLog2+1)'(1) << hl) - (MaxLog2+1)'(1);
    x0 = xs[XW-1:FracBits];
    y0 = ys[XW-1:FracBits];
    x1 = (x0 + MaxLog2'(1)) & wm[MaxLog2-1:0];
    y1 = (y0 + MaxLog2'(1)) & hm[MaxLog2-1:0];
    fx = xs[FracBits-1:0];
    fy = ys[FracBits-1:0];
    sx = One - {1'b0, fx};
    sy = One - {1'b0, fy};
    p0 = sx * sy;
    p1 = {1'b0, fx} * sy;
    p2 = sx * {1'b0, fy};
    p3 = {1'b0, fx} * {1'b0, fy};

    e = '0;
    if (item_i.operation == OP_LOAD) begin
      e.kind    = K_LOAD;
      e.addr[0] = item_i.texel_index;
      e.data    = {item_i.load_red, item_i.load_green, item_i.load_blue};
    end else if (!tex_en_q) begin
      e.kind  = K_NEAR;
      e.wt[0] = NearWt;
    end else if (!bil_en_q) begin
      e.kind    = K_NEAR;
      e.addr[0] = addr_of(ux[XW-1:FracBits], vx[XW-1:FracBits], wl, hl);
      e.wt[0]   = NearWt;
    end else begin
      e.kind    = K_BIL;
      e.addr[0] = addr_of(x0, y0, wl, hl);
      e.addr[1] = addr_of(x1, y0, wl, hl);
      e.addr[2] = addr_of(x0, y1, wl, hl);
      e.addr[3] = addr_of(x1, y1, wl, hl);
      e.wt[0]   = p0[WtW-1:0];
      e.wt[1]   = p1[WtW-1:0];
      e.wt[2]   = p2[WtW-1:0];
      e.wt[3]   = p3[WtW-1:0];
    end
  end

  assign entry_o = e;

endmodule

/* hw/rtl/txs_back.sv */
module txs_back import txs_pkg::*; #(
  parameter int FracBits = CoordFracBitsDef,
  localparam int WtW    = 2*FracBits + 1,
  localparam int EntryW = $bits(kind_e) + 4*StoreAw + TexelW + 4*WtW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [EntryW-1:0] entry_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_push_o,
  output out_item_t         out_data_o,
  input  logic              out_pop_i
);

  localparam int PW   = WtW + ChanW;
  localparam int AccW = PW + 2;
  localparam int CrW  = $clog2(OutDepth) + 1;
  localparam logic [AccW-1:0] Rnd = AccW'(1) << (2*FracBits - 1);

  typedef struct packed {
    kind_e                   kind;
    logic [3:0][StoreAw-1:0] addr;
    logic [TexelW-1:0]       data;
    logic [3:0][WtW-1:0]     wt;
  } entry_t;

  entry_t             e;
  logic               phase_q, phase_d;
  logic [CrW-1:0]     credit_q;
  logic               credit_ok, issue, last, reserve, we;
  logic [StoreAw-1:0] ra, rb;
  logic [TexelW-1:0]  rd_a, rd_b;

  assign e         = entry_t'(entry_i);
  assign credit_ok = credit_q < CrW'(OutDepth);

  always_comb begin
    issue   = 1'b0;
    q_pop_o = 1'b0;
    we      = 1'b0;
    last    = 1'b1;
    reserve = 1'b0;
    phase_d = phase_q;
    ra      = e.addr[0];
    rb      = e.addr[1];
    if (!q_empty_i) begin
      unique case (e.kind)
        K_LOAD: begin
          we      = 1'b1;
          q_pop_o = 1'b1;
        end
        K_NEAR: begin
          if (credit_ok) begin
            issue   = 1'b1;
            q_pop_o = 1'b1;
            reserve = 1'b1;
          end
        end
        K_BIL: begin
          if (phase_q) begin
            issue   = 1'b1;
            q_pop_o = 1'b1;
            phase_d = 1'b0;
            ra      = e.addr[2];
            rb      = e.addr[3];
          end else if (credit_ok) begin
            issue   = 1'b1;
            reserve = 1'b1;
            last    = 1'b0;
            phase_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  txs_ram #(.Width(TexelW), .Depth(1 << StoreAw)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(e.addr[0]), .wdata_i(e.data),
    .raddr_i(ra), .rdata_o(rd_a)
  );

  txs_ram #(.Width(TexelW), .Depth(1 << StoreAw)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(e.addr[0]), .wdata_i(e.data),
    .raddr_i(rb), .rdata_o(rd_b)
  );

  logic                    s1_valid_q, s1_last_q, s1_bil_q, s2_valid_q;
  logic [3:0][WtW-1:0]     s1_wt_q;
  logic [TexelW-1:0]       hold0_q, hold1_q;
  logic [3:0][TexelW-1:0]  tex;
  logic [3:0][2:0][PW-1:0] s2_p_q;
  logic [2:0][AccW-1:0]    acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      credit_q   <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      credit_q   <= credit_q + CrW'(reserve) - CrW'(out_pop_i);
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_last_q <= last;
      s1_bil_q  <= (e.kind == K_BIL);
      s1_wt_q   <= e.wt;
    end
    if (s1_valid_q && !s1_last_q) begin
      hold0_q <= rd_a;
      hold1_q <= rd_b;
    end
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        s2_p_q[k][c] <= s1_wt_q[k] * tex[k][ChanW*c +: ChanW];
      end
    end
  end

  assign tex = s1_bil_q ? {rd_b, rd_a, hold1_q, hold0_q} : {rd_a, rd_a, rd_a, rd_a};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AccW'(s2_p_q[0][c]) + AccW'(s2_p_q[1][c]) + AccW'(s2_p_q[2][c])
             + AccW'(s2_p_q[3][c]) + Rnd;
    end
  end

  assign out_push_o           = s2_valid_q;
  assign out_data_o.out_red   = acc[2][2*FracBits +: ChanW];
  assign out_data_o.out_green = acc[1][2*FracBits +: ChanW];
  assign out_data_o.out_blue  = acc[0][2*FracBits +: ChanW];

endmodule

/* hw/rtl/texture_sampler_wrap_bilinear.sv */
// Texture fetch unit with repeat wrapping and optional bilinear filtering.
// Input channel: push/full. A transaction with operation load writes one RGB
// texel into the 64K-entry texel store; a sample transaction returns one
// color on the result channel (empty/pop), oldest first.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, written while the unit idles.
// Issue: a load is popped as soon as it heads the queue; a nearest or
// disabled-texture sample, or the first half of a bilinear one, waits for
// a free output-queue slot; a bilinear sample reads two texel pairs in turn,
// since the store has two read ports (two copies) and needs four texels.
// Reset: queues empty, texturing and bilinear off, both sizes 256. Store
// contents are undefined until loaded; no clearing pass.
// When pop is held low, up to four results collect in the output queue,
// then the back end stalls, the two-entry queue fills and full rises.
module texture_sampler_wrap_bilinear import txs_pkg::*; #(
  parameter int MaxSizeLog2   = MaxSizeLog2Def,
  parameter int CoordFracBits = CoordFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int EntryW = $bits(kind_e) + 4*StoreAw + TexelW + 4*(2*CoordFracBits + 1);

  logic [EntryW-1:0] f_entry, q_entry;
  logic              q_empty, q_pop, out_push, out_full, out_pop;
  out_item_t         out_data;

  txs_front #(.MaxLog2(MaxSizeLog2), .FracBits(CoordFracBits)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(in_item_i), .entry_o(f_entry)
  );

  txs_fifo #(.Width(EntryW), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_entry), .full_o(full),
    .pop_i(q_pop), .data_o(q_entry), .empty_o(q_empty)
  );

  txs_back #(.FracBits(CoordFracBits)) u_back (
    .clk_i, .rst_ni, .entry_i(q_entry), .q_empty_i(q_empty), .q_pop_o(q_pop),
    .out_push_o(out_push), .out_data_o(out_data), .out_pop_i(out_pop)
  );

  assign out_pop = pop && !empty;

  txs_fifo #(.Width($bits(out_item_t)), .Depth(OutDepth)) u_out (
    .clk_i, .rst_ni, .push_i(out_push), .data_i(out_data), .full_o(out_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("result pushed into full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("back end popped empty queue");

endmodule

/* verif/tb_texture_sampler_wrap_bilinear.sv */
`timescale 1ns / 100ps

module tb_texture_sampler_wrap_bilinear;
  import txs_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int HoldCycles = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item_i;
  logic                empty;
  logic                pop;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  texture_sampler_wrap_bilinear dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the texel store and registers
  logic [TexelW-1:0] texels [0:65535];
  logic              tex_en;
  logic              bil_en;
  logic [Log2W-1:0]  wl_reg;
  logic [Log2W-1:0]  hl_reg;

  out_item_t color_q [$];
  int        errors;
  int        idle_mode;
  int        watch_cnt;
  bit        hold_go;
  int        hold_left;

  typedef struct {
    in_item_t  item;
    bit        chk;
    out_item_t color;
  } dir_row_t;

  typedef struct {
    logic       te;
    logic       be;
    logic [3:0] wl;
    logic [3:0] hl;
    int         mode;
  } phase_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TexelW-1:0] texel_at(int unsigned col, int unsigned rb,
                                                 int unsigned wl, int unsigned hl);
    int unsigned h;
    int unsigned row;
    h   = 1 << hl;
    row = (h - 1 - rb) & (h - 1);
    return texels[((row << wl) + col) & 16'hFFFF];
  endfunction

  function automatic out_item_t sample_color(logic [15:0] u, logic [15:0] v);
    longint unsigned one, uf, vf, half, xspan, yspan, xs, ys, fx, fy, rnd;
    longint unsigned wt [4];
    longint unsigned acc [3];
    logic [TexelW-1:0] tx [4];
    logic [TexelW-1:0] t;
    int unsigned wl, hl, w, h, x0, y0, x1, y1;
    out_item_t o;
    one = 64'd1 << CoordFracBitsDef;
    uf  = u & (one - 1);
    vf  = v & (one - 1);
    wl  = (wl_reg > MaxSizeLog2Def) ? MaxSizeLog2Def : wl_reg;
    hl  = (hl_reg > MaxSizeLog2Def) ? MaxSizeLog2Def : hl_reg;
    w   = 1 << wl;
    h   = 1 << hl;
    if (!tex_en) begin
      t = texels[0];
    end else if (!bil_en) begin
      t = texel_at(((uf << wl) >> CoordFracBitsDef) & (w - 1),
                   ((vf << hl) >> CoordFracBitsDef) & (h - 1), wl, hl);
    end else begin
      half  = one >> 1;
      xspan = longint'(w) << CoordFracBitsDef;
      yspan = longint'(h) << CoordFracBitsDef;
      xs = ((uf << wl) + xspan - half) & (xspan - 1);
      ys = ((vf << hl) + yspan - half) & (yspan - 1);
      x0 = (xs >> CoordFracBitsDef) & (w - 1);
      y0 = (ys >> CoordFracBitsDef) & (h - 1);
      x1 = (x0 + 1) & (w - 1);
      y1 = (y0 + 1) & (h - 1);
      fx = xs & (one - 1);
      fy = ys & (one - 1);
      wt[0] = (one - fx) * (one - fy);
      wt[1] = fx * (one - fy);
      wt[2] = (one - fx) * fy;
      wt[3] = fx * fy;
      tx[0] = texel_at(x0, y0, wl, hl);
      tx[1] = texel_at(x1, y0, wl, hl);
      tx[2] = texel_at(x0, y1, wl, hl);
      tx[3] = texel_at(x1, y1, wl, hl);
      acc = '{0, 0, 0};
      for (int k = 0; k < 4; k++) begin
        acc[0] += wt[k] * tx[k][23:16];
        acc[1] += wt[k] * tx[k][15:8];
        acc[2] += wt[k] * tx[k][7:0];
      end
      rnd = 64'd1 << (2 * CoordFracBitsDef - 1);
      o.out_red   = 8'((acc[0] + rnd) >> (2 * CoordFracBitsDef));
      o.out_green = 8'((acc[1] + rnd) >> (2 * CoordFracBitsDef));
      o.out_blue  = 8'((acc[2] + rnd) >> (2 * CoordFracBitsDef));
      return o;
    end
    o.out_red   = t[23:16];
    o.out_green = t[15:8];
    o.out_blue  = t[7:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // drives one transaction; returns after acceptance
  task automatic send_item(in_item_t it, bit chk, out_item_t want);
    push      <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    if (it.operation == OP_LOAD) begin
      texels[it.texel_index] = {it.load_red, it.load_green, it.load_blue};
    end else begin
      color_q.push_back(sample_color(it.coord_u, it.coord_v));
      if (chk && color_q[$] != want)
        report_mismatch("directed prediction", color_q[$], want);
    end
    if ((idle_mode == 1 && $urandom_range(99) < 61) ||
        (idle_mode == 3 && $urandom_range(99) < 10)) begin
      push <= 1'b0;
      do @(posedge clk_i);
      while ((idle_mode == 1 && $urandom_range(99) < 61) ||
             (idle_mode == 3 && $urandom_range(99) < 10));
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_TEX_EN:      tex_en = val[0];
      REG_BIL_EN:      bil_en = val[0];
      REG_WIDTH_LOG2:  wl_reg = val;
      REG_HEIGHT_LOG2: hl_reg = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t make_load(logic [15:0] idx, logic [23:0] c);
    in_item_t it;
    it = in_item_t'($urandom) | (in_item_t'($urandom) << 32) | (in_item_t'($urandom) << 64);
    it.operation   = OP_LOAD;
    it.texel_index = idx;
    {it.load_red, it.load_green, it.load_blue} = c;
    return it;
  endfunction

  function automatic in_item_t make_sample(logic [15:0] u, logic [15:0] v);
    in_item_t it;
    it = in_item_t'($urandom) | (in_item_t'($urandom) << 32) | (in_item_t'($urandom) << 64);
    it.operation = OP_SAMPLE;
    it.coord_u   = u;
    it.coord_v   = v;
    return it;
  endfunction

  function automatic out_item_t rgb(logic [23:0] c);
    return out_item_t'(c);
  endfunction

  // result side
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (color_q.size() == 0) begin
        $display("result with no pending sample: %0h", out_item_o);
        errors++;
      end else begin
        want = color_q.pop_front();
        if (out_item_o.out_red != want.out_red)
          report_mismatch("red", out_item_o.out_red, want.out_red);
        if (out_item_o.out_green != want.out_green)
          report_mismatch("green", out_item_o.out_green, want.out_green);
        if (out_item_o.out_blue != want.out_blue)
          report_mismatch("blue", out_item_o.out_blue, want.out_blue);
      end
    end
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (idle_mode == 2) begin
      pop <= ($urandom_range(99) >= 61);
    end else if (idle_mode == 3) begin
      pop <= ($urandom_range(99) >= 10);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    phase_t   phases [$];
    phase_t   ph;
    errors     = 0;
    idle_mode  = 0;
    watch_cnt  = 0;
    hold_go    = 1'b0;
    hold_left  = 0;
    tex_en     = 1'b0;
    bil_en     = 1'b0;
    wl_reg     = 4'd8;
    hl_reg     = 4'd8;
    rst_ni     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_TEX_EN;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // texturing off after reset: every sample returns entry zero
    dir_rows.push_back('{make_load(16'h0000, 24'hFF0080), 0, '0});
    dir_rows.push_back('{make_sample(16'h0000, 16'h0000), 1, rgb(24'hFF0080)});
    dir_rows.push_back('{make_sample(16'hFFFF, 16'hFFFF), 1, rgb(24'hFF0080)});
    dir_rows.push_back('{make_load(16'hFFFF, 24'hFFFFFF), 0, '0});
    dir_rows.push_back('{make_sample(16'h8000, 16'h0FFF), 1, rgb(24'hFF0080)});
    dir_rows.push_back('{make_load(16'h0000, 24'h000000), 0, '0});
    dir_rows.push_back('{make_sample(16'hFFFF, 16'h0000), 1, rgb(24'h000000)});
    dir_rows.push_back('{make_load(16'h0000, 24'h123456), 0, '0});
    dir_rows.push_back('{make_sample(16'h1000, 16'hF000), 1, rgb(24'h123456)});
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].color);
    drain();

    // fill the first 256 entries; every texture below fits in them
    for (int i = 0; i < 256; i++) send_item(make_load(16'(i), 24'($urandom)), 0, '0);
    drain();

    phases.push_back('{1'b1, 1'b0, 4'd8,  4'd0,  0});
    phases.push_back('{1'b1, 1'b1, 4'd4,  4'd4,  1});
    phases.push_back('{1'b1, 1'b1, 4'd0,  4'd0,  2});
    phases.push_back('{1'b1, 1'b0, 4'd0,  4'd4,  3});
    phases.push_back('{1'b1, 1'b1, 4'd15, 4'd0,  0});
    phases.push_back('{1'b1, 1'b0, 4'd3,  4'd5,  1});
    phases.push_back('{1'b0, 1'b1, 4'd2,  4'd2,  2});
    phases.push_back('{1'b1, 1'b1, 4'd1,  4'd6,  3});
    phases.push_back('{1'b1, 1'b1, 4'd0,  4'd15, 0});
    phases.push_back('{1'b1, 1'b0, 4'd9,  4'd0,  2});

    foreach (phases[p]) begin
      ph = phases[p];
      write_reg(REG_TEX_EN, ph.te);
      write_reg(REG_BIL_EN, ph.be);
      write_reg(REG_WIDTH_LOG2, ph.wl);
      write_reg(REG_HEIGHT_LOG2, ph.hl);
      cfg_we_i <= 1'b0;
      idle_mode = ph.mode;
      if (p == 0) hold_go = 1'b1;
      for (int n = 0; n < 24; n++) begin
        if (n == 12) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (color_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(99) < 25)
          send_item(make_load($urandom, $urandom), 0, '0);
        else
          send_item(make_sample($urandom, $urandom), 0, '0);
      end
      idle_mode = 0;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && color_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/txs_pkg.sv
hw/rtl/txs_ram.sv
hw/rtl/txs_fifo.sv
hw/rtl/txs_front.sv
hw/rtl/txs_back.sv
hw/rtl/texture_sampler_wrap_bilinear.sv
verif/tb_texture_sampler_wrap_bilinear.sv
